// ===== hdl/yiqlp_pkg.sv =====
// Shared types and constants for the YIQ luma point processor.
`timescale 1ns / 1ps
`default_nettype none
package yiqlp_pkg;

   localparam int CHAN_W     = 8;
   localparam int MODE_W     = 3;
   localparam int BRIGHT_W   = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [MODE_W-1:0] MODE_NONE      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_NEGATE    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ADD       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MULTIPLY  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_THRESHOLD = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] REG_MODE       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BRIGHTNESS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD  = 2'd2;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic signed [BRIGHT_W-1:0] brightness;
      logic [CHAN_W-1:0]          threshold;
   } cfg_type;

endpackage
`default_nettype wire

// ===== hdl/yiq_luma_point_processor.sv =====
// Top level: pipelined RGB to YIQ conversion, luma adjustment and conversion back.
//
//   Channel  Direction  Ports                              Moves
//   req      in         req_valid/ready, red/green/blue   one RGB pixel word
//   rsp      out        rsp_valid/ready, red/green/blue   one adjusted RGB word
//   csr      in         csr_valid/ready, index, wdata     one register write word
//
// The pipeline has six register stages, and a word passes through each of them in order;
// a new word is taken every cycle while rsp is not stalled.
// Reset clears the stage valid bits and sets mode 0, brightness 0, threshold 128.
// A stall on rsp holds stage 6 and every full stage directly behind it;
// a bubble further back is closed up by the stages behind it.
// The csr port is always ready and takes effect on the next cycle.
`timescale 1ns / 1ps
`default_nettype none
module yiq_luma_point_processor #(
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [yiqlp_pkg::CHAN_W-1:0]          req_red_in,
   input  logic [yiqlp_pkg::CHAN_W-1:0]          req_green_in,
   input  logic [yiqlp_pkg::CHAN_W-1:0]          req_blue_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [yiqlp_pkg::CHAN_W-1:0]          rsp_red_out,
   output logic [yiqlp_pkg::CHAN_W-1:0]          rsp_green_out,
   output logic [yiqlp_pkg::CHAN_W-1:0]          rsp_blue_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [yiqlp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [yiqlp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import yiqlp_pkg::*;

   localparam int F  = COEF_FRAC_BITS;
   localparam int CW = F + 2;
   localparam int PW = F + 11;
   localparam int SW = F + 10;
   localparam int LW = F + 18;
   localparam int VW = 2 * F + 20;

   localparam logic signed [CW-1:0] C_YR = CW'(((longint'(299) << F) + 500) / 1000);
   localparam logic signed [CW-1:0] C_YG = CW'(((longint'(587) << F) + 500) / 1000);
   localparam logic signed [CW-1:0] C_YB = CW'(((longint'(114) << F) + 500) / 1000);
   localparam logic signed [CW-1:0] C_IR = CW'(((longint'(596) << F) + 500) / 1000);
   localparam logic signed [CW-1:0] C_IG = CW'(((longint'(274) << F) + 500) / 1000);
   localparam logic signed [CW-1:0] C_IB = CW'(((longint'(322) << F) + 500) / 1000);
   localparam logic signed [CW-1:0] C_QR = CW'(((longint'(211) << F) + 500) / 1000);
   localparam logic signed [CW-1:0] C_QG = CW'(((longint'(523) << F) + 500) / 1000);
   localparam logic signed [CW-1:0] C_QB = CW'(((longint'(312) << F) + 500) / 1000);
   localparam logic signed [CW-1:0] C_RI = CW'(((longint'(956) << F) + 500) / 1000);
   localparam logic signed [CW-1:0] C_RQ = CW'(((longint'(621) << F) + 500) / 1000);
   localparam logic signed [CW-1:0] C_GI = CW'(((longint'(272) << F) + 500) / 1000);
   localparam logic signed [CW-1:0] C_GQ = CW'(((longint'(647) << F) + 500) / 1000);
   localparam logic signed [CW-1:0] C_BI = CW'(((longint'(1106) << F) + 500) / 1000);
   localparam logic signed [CW-1:0] C_BQ = CW'(((longint'(1703) << F) + 500) / 1000);

   localparam logic signed [VW-1:0] TOP = VW'(longint'(255)) <<< (2 * F);

   // Configuration registers.
   cfg_type cfg_ff, cfg_in;

   // Stage valid bits and advance enables.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic adv1, adv2, adv3, adv4, adv5, adv6;

   // Stage 1: forward matrix products.
   logic signed [PW-1:0] p_yr_ff, p_yg_ff, p_yb_ff, p_yr_in, p_yg_in, p_yb_in;
   logic signed [PW-1:0] p_ir_ff, p_ig_ff, p_ib_ff, p_ir_in, p_ig_in, p_ib_in;
   logic signed [PW-1:0] p_qr_ff, p_qg_ff, p_qb_ff, p_qr_in, p_qg_in, p_qb_in;
   logic signed [PW-1:0] r_ext, g_ext, b_ext;

   // Stage 2: Y, I and Q sums.
   logic signed [SW-1:0] y2_ff, i2_ff, q2_ff, y2_in, i2_in, q2_in;

   // Stage 3: adjusted luma.
   logic signed [LW-1:0] y3_ff, y3_in;
   logic signed [SW-1:0] i3_ff, q3_ff;

   // Stage 4: inverse matrix products.
   logic signed [VW-1:0] ys4_ff, ys4_in;
   logic signed [VW-1:0] ri4_ff, rq4_ff, gi4_ff, gq4_ff, bi4_ff, bq4_ff;
   logic signed [VW-1:0] ri4_in, rq4_in, gi4_in, gq4_in, bi4_in, bq4_in;
   logic signed [VW-1:0] i_ext, q_ext;

   // Stage 5: inverse sums.
   logic signed [VW-1:0] rs5_ff, gs5_ff, bs5_ff, rs5_in, gs5_in, bs5_in;

   // Stage 6: clamped output word.
   logic [CHAN_W-1:0] red6_ff, green6_ff, blue6_ff, red6_in, green6_in, blue6_in;

   function automatic logic [CHAN_W-1:0] clamp_channel(input logic signed [VW-1:0] v);
      logic [CHAN_W-1:0] res;
      if (v <= 0) begin
         res = '0;
      end else if (v > TOP) begin
         res = CHAN_MAX;
      end else begin
         res = v[2*F +: CHAN_W];
      end
      return res;
   endfunction

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MODE:       cfg_in.mode = csr_wdata[MODE_W-1:0];
            REG_BRIGHTNESS: cfg_in.brightness = $signed(csr_wdata[BRIGHT_W-1:0]);
            REG_THRESHOLD:  cfg_in.threshold = csr_wdata[CHAN_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   assign adv6 = !v6_ff || rsp_ready;
   assign adv5 = !v5_ff || adv6;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_ready = adv1;

   always_comb begin
      r_ext   = PW'($signed({1'b0, req_red_in}));
      g_ext   = PW'($signed({1'b0, req_green_in}));
      b_ext   = PW'($signed({1'b0, req_blue_in}));
      p_yr_in = PW'(C_YR) * r_ext;
      p_yg_in = PW'(C_YG) * g_ext;
      p_yb_in = PW'(C_YB) * b_ext;
      p_ir_in = PW'(C_IR) * r_ext;
      p_ig_in = PW'(C_IG) * g_ext;
      p_ib_in = PW'(C_IB) * b_ext;
      p_qr_in = PW'(C_QR) * r_ext;
      p_qg_in = PW'(C_QG) * g_ext;
      p_qb_in = PW'(C_QB) * b_ext;
   end

   always_comb begin
      y2_in = SW'(p_yr_ff + p_yg_ff + p_yb_ff);
      i2_in = SW'(p_ir_ff - p_ig_ff - p_ib_ff);
      q2_in = SW'(p_qr_ff - p_qg_ff + p_qb_ff);
   end

   yiqlp_luma_adjust #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_luma_adjust (
      .cfg      (cfg_ff),
      .luma     (y2_ff),
      .luma_adj (y3_in)
   );

   always_comb begin
      i_ext  = VW'(i3_ff);
      q_ext  = VW'(q3_ff);
      ys4_in = VW'(y3_ff) <<< F;
      ri4_in = VW'(C_RI) * i_ext;
      rq4_in = VW'(C_RQ) * q_ext;
      gi4_in = VW'(C_GI) * i_ext;
      gq4_in = VW'(C_GQ) * q_ext;
      bi4_in = VW'(C_BI) * i_ext;
      bq4_in = VW'(C_BQ) * q_ext;
   end

   always_comb begin
      rs5_in = ys4_ff + ri4_ff + rq4_ff;
      gs5_in = ys4_ff - gi4_ff - gq4_ff;
      bs5_in = ys4_ff - bi4_ff + bq4_ff;
   end

   always_comb begin
      red6_in   = clamp_channel(rs5_ff);
      green6_in = clamp_channel(gs5_ff);
      blue6_in  = clamp_channel(bs5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= MODE_NONE;
         cfg_ff.brightness <= '0;
         cfg_ff.threshold  <= 8'd128;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
         if (adv5) v5_ff <= v4_ff;
         if (adv6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         p_yr_ff <= p_yr_in;
         p_yg_ff <= p_yg_in;
         p_yb_ff <= p_yb_in;
         p_ir_ff <= p_ir_in;
         p_ig_ff <= p_ig_in;
         p_ib_ff <= p_ib_in;
         p_qr_ff <= p_qr_in;
         p_qg_ff <= p_qg_in;
         p_qb_ff <= p_qb_in;
      end
      if (adv2) begin
         y2_ff <= y2_in;
         i2_ff <= i2_in;
         q2_ff <= q2_in;
      end
      if (adv3) begin
         y3_ff <= y3_in;
         i3_ff <= i2_ff;
         q3_ff <= q2_ff;
      end
      if (adv4) begin
         ys4_ff <= ys4_in;
         ri4_ff <= ri4_in;
         rq4_ff <= rq4_in;
         gi4_ff <= gi4_in;
         gq4_ff <= gq4_in;
         bi4_ff <= bi4_in;
         bq4_ff <= bq4_in;
      end
      if (adv5) begin
         rs5_ff <= rs5_in;
         gs5_ff <= gs5_in;
         bs5_ff <= bs5_in;
      end
      if (adv6) begin
         red6_ff   <= red6_in;
         green6_ff <= green6_in;
         blue6_ff  <= blue6_in;
      end
   end

   assign rsp_valid     = v6_ff;
   assign rsp_red_out   = red6_ff;
   assign rsp_green_out = green6_ff;
   assign rsp_blue_out  = blue6_ff;

endmodule
`default_nettype wire

// ===== hdl/yiqlp_luma_adjust.sv =====
// Luma adjustment stage: applies the selected point operation to Y.
`timescale 1ns / 1ps
`default_nettype none
module yiqlp_luma_adjust #(
   parameter int COEF_FRAC_BITS = 14
) (
   input  yiqlp_pkg::cfg_type                  cfg,
   input  logic signed [COEF_FRAC_BITS+9:0]    luma,
   output logic signed [COEF_FRAC_BITS+17:0]   luma_adj
);
   import yiqlp_pkg::*;

   localparam int F  = COEF_FRAC_BITS;
   localparam int LW = F + 18;

   localparam logic signed [LW-1:0] FULL_SCALE = LW'(longint'(255) <<< F);

   logic signed [LW-1:0] y_wide;
   logic signed [LW-1:0] diff;
   logic signed [LW-1:0] thr_scaled;

   always_comb begin
      y_wide     = LW'(luma);
      diff       = y_wide - FULL_SCALE;
      thr_scaled = LW'({1'b0, cfg.threshold}) <<< F;
      case (cfg.mode)
         MODE_NEGATE:    luma_adj = diff[LW-1] ? -diff : diff;
         MODE_ADD:       luma_adj = y_wide + (LW'(cfg.brightness) <<< F);
         MODE_MULTIPLY:  luma_adj = y_wide * LW'(cfg.brightness);
         MODE_THRESHOLD: luma_adj = (y_wide > thr_scaled) ? FULL_SCALE : '0;
         default:        luma_adj = y_wide;
      endcase
   end

endmodule
`default_nettype wire
